// ===== sv/zph_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helper function of the Zobrist position hash.
package zph_pkg;

   // Generator constants.
   localparam logic [31:0] GEN_SEED = 32'd1804289383;
   localparam logic [31:0] GEN_MUL  = 32'd1103515245;
   localparam logic [31:0] GEN_ADD  = 32'd12345;

   // Board and key table geometry.
   localparam int SQUARES      = 64;
   localparam int PIECE_ROWS   = 12;
   localparam int PIECE_KEYS   = 768;
   localparam int CASTLE_KEYS  = 16;
   localparam int PASSANT_KEYS = 65;
   localparam int KEY_COUNT    = 850;
   localparam int KEY_CNT_W    = 10;
   localparam logic [6:0] NO_PASSANT = 7'd64;
   localparam logic [3:0] KIND_COUNT = 4'd12;

   // Default lane count.
   localparam int KEY_LANES = 8;

   // One key write from the fill sequencer.
   typedef struct packed {
      logic        piece;
      logic        castle;
      logic        passant;
      logic        turn;
      logic [3:0]  row;
      logic [6:0]  idx;
      logic [63:0] key;
   } fill_wr_type;

   // Row of the piece table for a piece kind: type * 2 + color.
   function automatic logic [3:0] kind_row(input logic [3:0] kind);
      logic [3:0] row;
      case (kind)
         4'd0:    row = 4'd0;
         4'd1:    row = 4'd2;
         4'd2:    row = 4'd4;
         4'd3:    row = 4'd6;
         4'd4:    row = 4'd8;
         4'd5:    row = 4'd10;
         4'd6:    row = 4'd1;
         4'd7:    row = 4'd3;
         4'd8:    row = 4'd5;
         4'd9:    row = 4'd7;
         4'd10:   row = 4'd9;
         4'd11:   row = 4'd11;
         default: row = 4'd0;
      endcase
      return row;
   endfunction

endpackage

// ===== sv/zph_keygen.sv =====
`timescale 1ns / 1ps
// Start-up sequencer that fills all key tables from the congruential generator.
module zph_keygen #(
   parameter int LANES  = zph_pkg::KEY_LANES,
   parameter int LANE_W = 1,
   parameter int STEP_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   output zph_pkg::fill_wr_type    wr,
   output logic [LANE_W-1:0]       wr_lane,
   output logic [STEP_W-1:0]       wr_step,
   output logic                    done
);

   localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(LANES - 1);

   logic [31:0]                       word_ff, word_in;
   logic [1:0]                        part_ff;
   logic [63:0]                       key_ff, key_in;
   logic [zph_pkg::KEY_CNT_W-1:0]     kcnt_ff;
   logic [LANE_W-1:0]                 lane_ff;
   logic [STEP_W-1:0]                 step_ff;
   logic                              done_ff;
   zph_pkg::fill_wr_type              wr_ff, wr_in;
   logic [LANE_W-1:0]                 wr_lane_ff;
   logic [STEP_W-1:0]                 wr_step_ff;
   logic [15:0]                       half;
   logic [zph_pkg::KEY_CNT_W-1:0]     castle_off, passant_off;

   // One generator step per cycle until the fill is done, and placement of its upper half in the key.
   always_comb begin
      word_in = word_ff * zph_pkg::GEN_MUL + zph_pkg::GEN_ADD;
      half    = word_in[31:16];
      key_in  = key_ff;
      case (part_ff)
         2'd0:    key_in[31:16] = half;
         2'd1:    key_in[15:0]  = half;
         2'd2:    key_in[63:48] = half;
         2'd3:    key_in[47:32] = half;
         default: key_in        = key_ff;
      endcase
   end

   // Target of the key that completes this cycle.
   always_comb begin
      castle_off  = kcnt_ff - zph_pkg::KEY_CNT_W'(zph_pkg::PIECE_KEYS);
      passant_off = kcnt_ff - zph_pkg::KEY_CNT_W'(zph_pkg::PIECE_KEYS + zph_pkg::CASTLE_KEYS);
      wr_in         = '0;
      wr_in.key     = key_in;
      wr_in.row     = kcnt_ff[9:6];
      wr_in.piece   = kcnt_ff < zph_pkg::KEY_CNT_W'(zph_pkg::PIECE_KEYS);
      wr_in.castle  = !wr_in.piece &&
                      kcnt_ff < zph_pkg::KEY_CNT_W'(zph_pkg::PIECE_KEYS + zph_pkg::CASTLE_KEYS);
      wr_in.turn    = kcnt_ff == zph_pkg::KEY_CNT_W'(zph_pkg::KEY_COUNT - 1);
      wr_in.passant = !wr_in.piece && !wr_in.castle && !wr_in.turn;
      wr_in.idx     = wr_in.castle ? {3'd0, castle_off[3:0]} : passant_off[6:0];
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff    <= zph_pkg::GEN_SEED;
         part_ff    <= 2'd0;
         key_ff     <= '0;
         kcnt_ff    <= '0;
         lane_ff    <= '0;
         step_ff    <= '0;
         done_ff    <= 1'b0;
         wr_ff      <= '0;
         wr_lane_ff <= '0;
         wr_step_ff <= '0;
      end else begin
         wr_ff <= (!done_ff && part_ff == 2'd3) ? wr_in : '0;
         if (!done_ff) begin
            word_ff <= word_in;
            part_ff <= part_ff + 2'd1;
            key_ff  <= key_in;
            if (part_ff == 2'd3) begin
               wr_lane_ff <= lane_ff;
               wr_step_ff <= step_ff;
               kcnt_ff    <= kcnt_ff + 1'b1;
               if (kcnt_ff[5:0] == 6'd63) begin
                  lane_ff <= '0;
                  step_ff <= '0;
               end else if (lane_ff == LAST_LANE) begin
                  lane_ff <= '0;
                  step_ff <= step_ff + 1'b1;
               end else begin
                  lane_ff <= lane_ff + 1'b1;
               end
               if (wr_in.turn) begin
                  done_ff <= 1'b1;
               end
            end
         end
      end
   end

   assign wr      = wr_ff;
   assign wr_lane = wr_lane_ff;
   assign wr_step = wr_step_ff;
   assign done    = done_ff;

endmodule

// ===== sv/zph_lane.sv =====
`timescale 1ns / 1ps
// One key lane: a bank of square keys with a registered, gated read.
module zph_lane #(
   parameter int DEPTH  = 96,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [63:0]       wr_key,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [63:0]       key
);

   logic [63:0] bank [DEPTH];
   logic [63:0] data_ff;
   logic        en_ff;

   // Key bank with one write and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank[wr_addr] <= wr_key;
      end
      data_ff <= bank[rd_addr];
   end

   // Read enable is registered alongside the read data.
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0;
      end else begin
         en_ff <= rd_en;
      end
   end

   assign key = en_ff ? data_ff : 64'd0;

endmodule

// ===== sv/zph_merge.sv =====
`timescale 1ns / 1ps
// Merging stage: folds all lane keys into the running hash.
module zph_merge #(
   parameter int LANES = zph_pkg::KEY_LANES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] lane_key [LANES],
   input  logic        clear,
   output logic [63:0] hash
);

   logic [63:0] acc_ff, acc_in;
   logic [63:0] fold;

   // XOR of every lane's key this cycle, folded into the running hash unless clear is set.
   always_comb begin
      fold = 64'd0;
      for (int l = 0; l < LANES; l++) begin
         fold = fold ^ lane_key[l];
      end
      acc_in = clear ? 64'd0 : (acc_ff ^ fold);
   end

   // Running hash register.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 64'd0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign hash = acc_ff;

endmodule

// ===== sv/zobrist_position_hash.sv =====
`timescale 1ns / 1ps
// Top level of the Zobrist position hash with banked key lanes.
// After reset the key tables fill from 850 keys of four generator steps each;
// req_stall stays high until the fill is done.
// Each bitboard is scanned with one bank read per lane per cycle. The hash of the last
// bitboard is registered onto rsp_hash_key once the output register is free or being taken.
// Reset is synchronous and active high and restarts the fill.
module zobrist_position_hash #(
   parameter int KEY_LANES = zph_pkg::KEY_LANES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_piece_kind,
   input  logic [63:0] req_occupancy,
   input  logic [3:0]  req_castling_rights,
   input  logic [6:0]  req_ep_square,
   input  logic        req_black_to_move,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_key
);

   localparam int STEPS  = (zph_pkg::SQUARES + KEY_LANES - 1) / KEY_LANES;
   localparam int LANE_W = (KEY_LANES > 1) ? $clog2(KEY_LANES) : 1;
   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int DEPTH  = zph_pkg::PIECE_ROWS * STEPS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_type;

   state_type            state_ff;
   logic [STEP_W-1:0]    step_ff;
   logic                 drain_ff;
   logic [63:0]          fresh_ff;
   logic [63:0]          claimed_ff;
   logic [3:0]           row_ff;
   logic [3:0]           castle_ff;
   logic [6:0]           ep_ff;
   logic                 black_ff;
   logic                 last_ff;
   logic                 rsp_valid_ff;
   logic [63:0]          rsp_hash_ff;
   logic [63:0]          turn_key_ff;

   zph_pkg::fill_wr_type wr;
   logic [LANE_W-1:0]    wr_lane;
   logic [STEP_W-1:0]    wr_step;
   logic                 fill_done;

   logic [63:0]          castle_mem [zph_pkg::CASTLE_KEYS];
   logic [63:0]          passant_mem [zph_pkg::PASSANT_KEYS];
   logic [63:0]          castle_key_ff;
   logic [63:0]          passant_key_ff;
   logic [6:0]           ep_idx;

   logic [ADDR_W-1:0]    wr_addr, rd_addr;
   logic [63:0]          lane_key [KEY_LANES];
   logic [63:0]          run_hash;
   logic                 req_take, rsp_take, rsp_load;
   logic                 kind_ok;

   // Key table fill.
   zph_keygen #(
      .LANES  (KEY_LANES),
      .LANE_W (LANE_W),
      .STEP_W (STEP_W)
   ) u_keygen (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .wr_lane (wr_lane),
      .wr_step (wr_step),
      .done    (fill_done)
   );

   // Handshake decode.
   assign req_stall = !(state_ff == S_IDLE && fill_done);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_load  = state_ff == S_FINISH && last_ff && (!rsp_valid_ff || !rsp_stall);
   assign kind_ok   = req_piece_kind < zph_pkg::KIND_COUNT;

   // Bank addresses: row of the piece kind times steps plus step.
   assign wr_addr = ADDR_W'(ADDR_W'(wr.row) * ADDR_W'(STEPS) + ADDR_W'(wr_step));
   assign rd_addr = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(STEPS) + ADDR_W'(step_ff));

   // Square key lanes.
   for (genvar l = 0; l < KEY_LANES; l++) begin : g_lane
      zph_lane #(
         .DEPTH  (DEPTH),
         .ADDR_W (ADDR_W)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .wr_en   (wr.piece && wr_lane == LANE_W'(l)),
         .wr_addr (wr_addr),
         .wr_key  (wr.key),
         .rd_en   (state_ff == S_SCAN && fresh_ff[l]),
         .rd_addr (rd_addr),
         .key     (lane_key[l])
      );
   end

   // Merge of lane results.
   zph_merge #(
      .LANES (KEY_LANES)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .lane_key (lane_key),
      .clear    (rsp_load),
      .hash     (run_hash)
   );

   // Castle and en-passant key memories and the turn key.
   assign ep_idx = ep_ff[6] ? zph_pkg::NO_PASSANT : ep_ff;

   always_ff @(posedge clock) begin
      if (wr.castle) begin
         castle_mem[wr.idx[3:0]] <= wr.key;
      end
      if (wr.passant) begin
         passant_mem[wr.idx] <= wr.key;
      end
      if (wr.turn) begin
         turn_key_ff <= wr.key;
      end
      castle_key_ff  <= castle_mem[castle_ff];
      passant_key_ff <= passant_mem[ep_idx];
   end

   // Transaction sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         drain_ff     <= 1'b0;
         fresh_ff     <= '0;
         claimed_ff   <= '0;
         row_ff       <= '0;
         castle_ff    <= '0;
         ep_ff        <= '0;
         black_ff     <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_hash_ff  <= '0;
      end else begin
         if (rsp_take && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  row_ff    <= zph_pkg::kind_row(req_piece_kind);
                  castle_ff <= req_castling_rights;
                  ep_ff     <= req_ep_square;
                  black_ff  <= req_black_to_move;
                  last_ff   <= req_last;
                  step_ff   <= '0;
                  if (kind_ok) begin
                     fresh_ff   <= req_occupancy & ~claimed_ff;
                     claimed_ff <= claimed_ff | req_occupancy;
                  end else begin
                     fresh_ff <= '0;
                  end
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               fresh_ff <= fresh_ff >> KEY_LANES;
               if (step_ff == LAST_STEP) begin
                  drain_ff <= 1'b0;
                  state_ff <= S_DRAIN;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               drain_ff <= 1'b1;
               if (drain_ff) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (rsp_load) begin
                  rsp_hash_ff  <= run_hash ^ castle_key_ff ^ passant_key_ff ^
                                  (black_ff ? turn_key_ff : 64'd0);
                  rsp_valid_ff <= 1'b1;
                  claimed_ff   <= '0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hash_key = rsp_hash_ff;

`ifndef NO_ASSERTIONS
   // No transaction is taken while the key tables are still filling.
   assert property (@(posedge clock) disable iff (reset) !fill_done |-> req_stall)
      else $error("request accepted during key fill");

   // Once filled, the tables stay filled until the next reset.
   assert property (@(posedge clock) disable iff (reset) fill_done |=> fill_done)
      else $error("fill done dropped");

   // A result is only loaded into a free or draining output register.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwrote a pending result");

   // The running state is clear after a position's hash has been loaded.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (run_hash == 64'd0 && claimed_ff == 64'd0))
      else $error("running state not cleared after result");
`endif

endmodule
